### rtl/core/slcs_pkg.sv
// Shared types, widths and helpers for the sparse linear classifier score unit.
// No dependencies; imported by the top level.
package slcs_pkg;

    localparam int IDX_W   = 16;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SCORE_W = 48;

    localparam int unsigned NUM_WEIGHTS_DEF = 32'd65536;

    // reciprocal scaling for the index reduction
    localparam int RECIP_SH = 32;

    localparam logic signed [SCORE_W-1:0] RHO_RESET = 48'sd16777216;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // clamp a value one bit wider than the score back into score range
    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [SCORE_W:0] x
    );
        logic signed [SCORE_W-1:0] r;
        if (x[SCORE_W] != x[SCORE_W-1])
        begin
            r = x[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end
        else
        begin
            r = x[SCORE_W-1:0];
        end
        return r;
    endfunction

    // per-stage handshake state passed around the scoring pipeline
    typedef struct packed {
        logic s1_free;
        logic s2_adv;
        logic s3_free;
        logic out_free;
    } pipe_ctl_t;

endpackage

### rtl/core/sparse_linear_classifier_score_unit.sv
// Sparse linear one-class SVM scorer: weight memory, saturating MAC, margin stage.
// Depends on slcs_pkg and slcs_ram.
//
// Takes one request per cycle, weight writes and features alike, and keeps
// taking them while a result waits at the output until all pipeline stages are
// full. A feature passes index reduction, weight read, multiply, accumulate and
// margin stages, registered in a, s1, s2, s3 and the output register. The rate
// is set by the single weight memory port pair: one write or one read per
// cycle. The feature index wraps modulo NUM_WEIGHTS. Weights read before being
// written return whatever the memory holds. rho must be written on the cfg
// channel only while no vector is in flight; the block does not enforce this.
module sparse_linear_classifier_score_unit
    import slcs_pkg::*;
#(
    parameter int unsigned NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [IDX_W-1:0]          feature_index,
    input  logic signed [VAL_W-1:0]   item_value,
    input  logic                      last_feature,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SCORE_W-1:0] score_margin,
    output logic                      is_inlier,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic signed [SCORE_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(NUM_WEIGHTS);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SH) + 64'(NUM_WEIGHTS) - 64'd1) / 64'(NUM_WEIGHTS);
    localparam int QP_W = IDX_W + RECIP_SH;

    // ---- stage a: quotient estimate registered with the request ----
    logic                    a_valid_reg, a_valid_next;
    logic                    a_op_reg;
    logic [IDX_W-1:0]        a_idx_reg;
    logic [IDX_W-1:0]        a_q_reg;
    logic signed [VAL_W-1:0] a_val_reg;
    logic                    a_last_reg;

    // ---- stage s1: weight read in flight ----
    logic                    s1_valid_reg, s1_valid_next;
    logic signed [VAL_W-1:0] s1_val_reg;
    logic                    s1_last_reg;

    // ---- stage s2: product ----
    logic                     s2_valid_reg, s2_valid_next;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic                     s2_last_reg;

    // ---- stage s3: final score ----
    logic                      s3_valid_reg, s3_valid_next;
    logic signed [SCORE_W-1:0] s3_score_reg;

    logic signed [SCORE_W-1:0] acc_reg, acc_next;
    logic signed [SCORE_W-1:0] rho_reg;

    logic                      out_valid_reg, out_valid_next;
    logic signed [SCORE_W-1:0] score_margin_reg;
    logic                      is_inlier_reg;

    pipe_ctl_t ctl;

    logic                    in_fire;
    logic                    a_adv;
    logic                    a_is_feat;
    logic [QP_W-1:0]         q_prod;
    logic [31:0]             qn;
    logic [31:0]             idx_rem;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    mem_we, mem_re;
    logic [VAL_W-1:0]        mem_rdata;
    logic                    s2_fire, s3_fire;
    logic signed [SCORE_W:0] acc_sum;
    logic signed [SCORE_W-1:0] acc_sat;
    logic signed [SCORE_W:0] margin_full;

    // ready chain, back to front
    always_comb
    begin
        ctl.out_free = !out_valid_reg || out_ready;
        ctl.s3_free  = !s3_valid_reg || ctl.out_free;
        ctl.s2_adv   = !s2_last_reg || ctl.s3_free;
        ctl.s1_free  = !s1_valid_reg || !s2_valid_reg || ctl.s2_adv;
    end

    assign a_is_feat = a_op_reg == OP_FEATURE;
    assign a_adv     = !a_valid_reg || !a_is_feat || ctl.s1_free;
    assign in_ready  = a_adv;
    assign in_fire   = in_valid && in_ready;

    // floor(idx / N) via reciprocal; exact for 16-bit indices
    assign q_prod = QP_W'(feature_index) * QP_W'(RECIP);

    // remainder: idx - q*N never goes negative
    assign qn       = 32'(a_q_reg) * 32'(NUM_WEIGHTS);
    assign idx_rem  = 32'(a_idx_reg) - qn;
    assign mem_addr = idx_rem[ADDR_W-1:0];

    assign mem_we = a_valid_reg && !a_is_feat;
    assign mem_re = a_valid_reg && a_is_feat && ctl.s1_free;

    slcs_ram #(
        .DATA_W (VAL_W),
        .DEPTH  (NUM_WEIGHTS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (a_val_reg),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    assign s2_fire = s2_valid_reg && ctl.s2_adv;
    assign s3_fire = s3_valid_reg && ctl.out_free;

    assign acc_sum = (SCORE_W+1)'(acc_reg) + (SCORE_W+1)'(s2_prod_reg);
    assign acc_sat = sat_score(acc_sum);

    assign margin_full = (SCORE_W+1)'(s3_score_reg) - (SCORE_W+1)'(rho_reg);

    always_comb
    begin
        a_valid_next = a_adv ? in_fire : a_valid_reg;

        s1_valid_next = s1_valid_reg;
        if (ctl.s1_free)
        begin
            s1_valid_next = mem_re;
        end

        s2_valid_next = s2_valid_reg;
        if (!s2_valid_reg || ctl.s2_adv)
        begin
            s2_valid_next = s1_valid_reg;
        end

        s3_valid_next = s3_valid_reg;
        if (s2_fire && s2_last_reg)
        begin
            s3_valid_next = 1'b1;
        end
        else if (s3_fire)
        begin
            s3_valid_next = 1'b0;
        end

        acc_next = acc_reg;
        if (s2_fire)
        begin
            acc_next = s2_last_reg ? '0 : acc_sat;
        end

        out_valid_next = out_valid_reg;
        if (s3_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            rho_reg       <= RHO_RESET;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            if (cfg_valid && cfg_ready)
            begin
                rho_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_op_reg   <= op;
            a_idx_reg  <= feature_index;
            a_q_reg    <= q_prod[QP_W-1:RECIP_SH];
            a_val_reg  <= item_value;
            a_last_reg <= last_feature;
        end
        if (mem_re)
        begin
            s1_val_reg  <= a_val_reg;
            s1_last_reg <= a_last_reg;
        end
        if (s1_valid_reg && (!s2_valid_reg || ctl.s2_adv))
        begin
            s2_prod_reg <= $signed(mem_rdata) * s1_val_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_fire && s2_last_reg)
        begin
            s3_score_reg <= acc_sat;
        end
        if (s3_fire)
        begin
            score_margin_reg <= sat_score(margin_full);
            is_inlier_reg    <= !margin_full[SCORE_W];
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign score_margin = score_margin_reg;
    assign is_inlier    = is_inlier_reg;

endmodule

### rtl/core/slcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module slcs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
